>>> rtl/scp_pkg.sv
package scp_pkg;

    // Result action codes.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_REPLY = 3'd1;
    localparam logic [2:0] ACT_SERVO = 3'd2;
    localparam logic [2:0] ACT_APPLY = 3'd3;
    localparam logic [2:0] ACT_ADC   = 3'd4;

    // Command characters of the protocol.
    localparam logic [7:0] CH_VERSION = 8'h56;  // 'V'
    localparam logic [7:0] CH_ONE     = 8'h31;  // '1'
    localparam logic [7:0] CH_BULK    = 8'h53;  // 'S'
    localparam logic [7:0] CH_APPLY   = 8'h45;  // 'E'
    localparam logic [7:0] CH_ADC     = 8'h41;  // 'A'
    localparam logic [7:0] CH_SINGLE  = 8'h4E;  // 'N'
    localparam logic [7:0] CH_MODE    = 8'h4D;  // 'M'

    localparam logic [7:0] MAX_ANGLE  = 8'd180;
    localparam logic [7:0] BULK_MODE  = 8'd1;

    // Register map, word addressed.
    localparam logic [0:0] REG_PW_ZERO = 1'b0;
    localparam logic [0:0] REG_PW_FULL = 1'b1;

    // ceil(2^32 / 180). With a dividend below 2^24 the quotient taken from
    // bits 47:32 of the product is exact.
    localparam logic [24:0] RECIP_180 = 25'd23860930;

    typedef enum logic [2:0] {
        PS_IDLE   = 3'd0,
        PS_BULK   = 3'd1,
        PS_INDEX  = 3'd2,
        PS_SINGLE = 3'd3,
        PS_MODE   = 3'd4
    } parse_state_t;

    // Decoded command for one received word.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] reply;
        logic [2:0] idx;
        logic [7:0] angle;
    } cmd_t;

    // Load enables of the three stages behind the decoder.
    typedef struct packed {
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  reply;
        logic [2:0]  idx;
        logic [15:0] pulse;
    } result_t;

endpackage

>>> rtl/scp_cmd_decode.sv
module scp_cmd_decode #(
    parameter int NUM_SERVOS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_in,
    output scp_pkg::cmd_t cmd
);
    import scp_pkg::*;

    localparam logic [7:0] SERVO_LIMIT = 8'(NUM_SERVOS);

    parse_state_t state_reg, state_next;
    logic [7:0]   counter_reg, counter_next;
    logic [7:0]   mode_reg, mode_next;
    logic [7:0]   counter_inc;
    logic [7:0]   angle_clamped;

    assign counter_inc   = counter_reg + 8'd1;
    assign angle_clamped = (byte_in > MAX_ANGLE) ? MAX_ANGLE : byte_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PS_IDLE;
            counter_reg <= 8'd0;
            mode_reg    <= 8'd0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            mode_reg    <= mode_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        counter_next = counter_reg;
        mode_next    = mode_reg;
        case (state_reg)
            PS_IDLE:
            begin
                case (byte_in)
                    CH_BULK:
                    begin
                        if (mode_reg == BULK_MODE)
                        begin
                            state_next = PS_BULK;
                        end
                    end
                    CH_SINGLE: state_next = PS_INDEX;
                    CH_MODE:   state_next = PS_MODE;
                    default:   state_next = PS_IDLE;
                endcase
            end
            PS_BULK:
            begin
                if (counter_reg < SERVO_LIMIT && counter_inc < SERVO_LIMIT)
                begin
                    counter_next = counter_inc;
                end
                else
                begin
                    counter_next = 8'd0;
                    state_next   = PS_IDLE;
                end
            end
            PS_INDEX:
            begin
                counter_next = byte_in;
                state_next   = PS_SINGLE;
            end
            PS_SINGLE:
            begin
                counter_next = 8'd0;
                state_next   = PS_IDLE;
            end
            PS_MODE:
            begin
                mode_next  = byte_in;
                state_next = PS_IDLE;
            end
            default: state_next = PS_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            PS_IDLE:
            begin
                case (byte_in)
                    CH_VERSION:
                    begin
                        cmd.action = ACT_REPLY;
                        cmd.reply  = CH_ONE;
                    end
                    CH_APPLY: cmd.action = ACT_APPLY;
                    CH_ADC:   cmd.action = ACT_ADC;
                    default:  cmd.action = ACT_NONE;
                endcase
            end
            PS_BULK, PS_SINGLE:
            begin
                if (counter_reg < SERVO_LIMIT)
                begin
                    cmd.action = ACT_SERVO;
                    cmd.idx    = counter_reg[2:0];
                    cmd.angle  = angle_clamped;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/scp_pulse_map.sv
module scp_pulse_map (
    input  logic                clk,
    input  scp_pkg::pipe_ctrl_t ctrl,
    input  scp_pkg::cmd_t       cmd,
    input  logic [15:0]         pw_zero,
    input  logic [15:0]         pw_full,
    output scp_pkg::result_t    res
);
    import scp_pkg::*;

    logic        span_neg;
    logic [15:0] span_mag;
    logic [23:0] prod_next;
    logic [48:0] recip_prod;
    logic [15:0] quot_next;
    logic [15:0] pulse_next;

    cmd_t        cmd2_reg, cmd3_reg;
    logic [23:0] prod2_reg;
    logic        neg2_reg, neg3_reg;
    logic [15:0] quot3_reg;
    result_t     res_reg;

    // Magnitude and sign of the span; the map works on magnitudes so that
    // the quotient truncates toward zero.
    assign span_neg  = pw_full < pw_zero;
    assign span_mag  = span_neg ? (pw_zero - pw_full) : (pw_full - pw_zero);
    assign prod_next = cmd.angle * span_mag;

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            cmd2_reg  <= cmd;
            prod2_reg <= prod_next;
            neg2_reg  <= span_neg;
        end
    end

    assign recip_prod = prod2_reg * RECIP_180;
    assign quot_next  = recip_prod[47:32];

    always_ff @(posedge clk)
    begin
        if (ctrl.load3)
        begin
            cmd3_reg  <= cmd2_reg;
            quot3_reg <= quot_next;
            neg3_reg  <= neg2_reg;
        end
    end

    always_comb
    begin
        if (cmd3_reg.action == ACT_SERVO)
        begin
            pulse_next = neg3_reg ? (pw_zero - quot3_reg) : (pw_zero + quot3_reg);
        end
        else
        begin
            pulse_next = 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load4)
        begin
            res_reg.action <= cmd3_reg.action;
            res_reg.reply  <= cmd3_reg.reply;
            res_reg.idx    <= cmd3_reg.idx;
            res_reg.pulse  <= pulse_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/servo_command_parser.sv
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ---------------------------------------------
// input    in         in_valid/in_stall    rx_byte
// output   out        out_valid/out_stall  action, reply_byte, servo_index, pulse_width
// config   in         APB psel/penable     paddr, pwdata, prdata (pulse limits)
//
// Each received word passes four register stages: an input register, the
// decoded command with the angle times span product, the quotient by 180
// from a reciprocal multiply, and the output register. One word can be
// accepted every cycle while the input is not stalled. Reset clears the
// parser state, the mode, the stage valid bits and puts the pulse registers
// at 1000 and 2000. A stall at the output only holds stages that are full;
// empty stages in front keep filling, so the input stalls only once every
// stage holds a word.
module servo_command_parser #(
    parameter int NUM_SERVOS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // Received word channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  reply_byte,
    output logic [2:0]  servo_index,
    output logic [15:0] pulse_width,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scp_pkg::*;

    logic [15:0] pw_zero_reg;
    logic [15:0] pw_full_reg;
    logic        cfg_write;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        ready1, ready2, ready3, ready4;
    logic [7:0]  byte1_reg;
    pipe_ctrl_t  ctrl;
    cmd_t        cmd;
    result_t     res;

    // Configuration registers. The word address is taken from bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_zero_reg <= 16'd1000;
            pw_full_reg <= 16'd2000;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_PW_ZERO: pw_zero_reg <= pwdata[15:0];
                REG_PW_FULL: pw_full_reg <= pwdata[15:0];
                default:     pw_zero_reg <= pw_zero_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PW_ZERO: prdata = {16'd0, pw_zero_reg};
            REG_PW_FULL: prdata = {16'd0, pw_full_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // A stage takes a new word when it is empty or its word moves on.
    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign in_stall   = !ready1;
    assign ctrl.load2 = ready2;
    assign ctrl.load3 = ready3;
    assign ctrl.load4 = ready4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            byte1_reg <= rx_byte;
        end
    end

    // The parser state moves only when a real word leaves the input register.
    scp_cmd_decode #(
        .NUM_SERVOS(NUM_SERVOS)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (v1_reg && ready2),
        .byte_in(byte1_reg),
        .cmd    (cmd)
    );

    scp_pulse_map u_map (
        .clk    (clk),
        .ctrl   (ctrl),
        .cmd    (cmd),
        .pw_zero(pw_zero_reg),
        .pw_full(pw_full_reg),
        .res    (res)
    );

    assign out_valid   = v4_reg;
    assign action      = res.action;
    assign reply_byte  = res.reply;
    assign servo_index = res.idx;
    assign pulse_width = res.pulse;

endmodule
